### rtl/core/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
`default_nettype none

package ffra_pkg;

	// free list geometry
	localparam int FREE_SLOTS = 64;
	localparam int IDX_W      = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CNT_W      = $clog2(FREE_SLOTS + 1);

	// slot numbers and pool size
	localparam int SLOT_W = 27;
	localparam logic [SLOT_W-1:0] POOL_RESET = 27'd41000000;

	// request modes
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_REINIT  = 2'd2;

	// response status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] alloc_length;
		logic [SLOT_W-1:0] release_start;
		logic [SLOT_W-1:0] release_end;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_start;
		logic [6:0]        free_range_count;
	} rsp_t;

	// one free range [rstart, rend)
	typedef struct packed {
		logic [SLOT_W-1:0] rstart;
		logic [SLOT_W-1:0] rend;
	} range_t;

	localparam int RANGE_W = $bits(range_t);

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} done_t;

endpackage

`default_nettype wire

### rtl/core/ffra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ffra_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 54,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/ffra_ctrl.sv
// Request sequencer: walks the free-range RAM for search, merge and shifting.
`default_nettype none

module ffra_ctrl
	import ffra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	input  wire logic [SLOT_W-1:0] pool_size,
	input  wire logic              rsp_free,
	output done_t                  done,
	output logic                   mem_we,
	output logic      [IDX_W-1:0]  mem_waddr,
	output range_t                 mem_wdata,
	output logic                   mem_re,
	output logic      [IDX_W-1:0]  mem_raddr,
	input  wire range_t            mem_rdata
);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_REL  = 3'd3;
	localparam logic [2:0] S_SHDN = 3'd4;
	localparam logic [2:0] S_SHUP = 3'd5;
	localparam logic [2:0] S_INS  = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(FREE_SLOTS);

	logic [2:0]        state_q, state_d;
	req_t              req_q, req_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	range_t            prev_q, prev_d;
	range_t            next_q, next_d;
	logic              hp_q, hp_d;
	logic              hn_q, hn_d;
	logic [1:0]        status_q, status_d;
	logic [SLOT_W-1:0] granted_q, granted_d;

	// helper values used by several states
	logic [CNT_W-1:0]  idx_p1, idx_p2, idx_m1, idx_m2, pos_m1, pos_p1, cnt_m1;
	logic              more;
	logic [SLOT_W-1:0] new_start;
	logic              fit, mprev, mnext;

	assign idx_p1    = idx_q + ONE;
	assign idx_p2    = idx_q + TWO;
	assign idx_m1    = idx_q - ONE;
	assign idx_m2    = idx_q - TWO;
	assign pos_m1    = pos_q - ONE;
	assign pos_p1    = pos_q + ONE;
	assign cnt_m1    = count_q - ONE;
	assign more      = idx_p1 < count_q;
	assign new_start = mem_rdata.rstart + req_q.alloc_length;
	assign fit       = (mem_rdata.rend - mem_rdata.rstart) >= req_q.alloc_length;
	assign mprev     = hp_q && (prev_q.rend == req_q.release_start);
	assign mnext     = hn_q && (next_q.rstart == req_q.release_end);

	assign req_stall = (state_q != S_IDLE);
	assign done.valid = (state_q == S_RESP);
	assign done.rsp   = '{status: status_q, granted_start: granted_q,
		free_range_count: 7'(count_q)};

	// next-state and RAM access decode
	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		prev_d    = prev_q;
		next_d    = next_q;
		hp_d      = hp_q;
		hn_d      = hn_q;
		status_d  = status_q;
		granted_d = granted_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			// put the reset range into entry 0
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '{rstart: '0, rend: POOL_RESET};
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					req_d     = req;
					granted_d = '0;
					status_d  = ST_DONE;
					hp_d      = 1'b0;
					hn_d      = 1'b0;
					idx_d     = '0;
					pos_d     = '0;
					case (req.mode)
						MODE_ALLOC: begin
							if (req.alloc_length == '0) begin
								status_d = ST_IGNORED;
								state_d  = S_RESP;
							end else if (count_q == '0) begin
								status_d = ST_NOFIT;
								state_d  = S_RESP;
							end else begin
								mem_re  = 1'b1;
								state_d = S_SCAN;
							end
						end
						MODE_RELEASE: begin
							if (req.release_end <= req.release_start) begin
								status_d = ST_IGNORED;
								state_d  = S_RESP;
							end else if (count_q == '0) begin
								state_d = S_REL;
							end else begin
								mem_re  = 1'b1;
								state_d = S_SCAN;
							end
						end
						MODE_REINIT: begin
							mem_we    = 1'b1;
							mem_wdata = '{rstart: '0, rend: pool_size};
							count_d   = (pool_size != '0) ? ONE : '0;
							state_d   = S_RESP;
						end
						default: begin
							status_d = ST_IGNORED;
							state_d  = S_RESP;
						end
					endcase
				end
			end
			// one entry per cycle; the next entry is read ahead
			S_SCAN: begin
				mem_re    = more;
				mem_raddr = idx_p1[IDX_W-1:0];
				if (req_q.mode == MODE_ALLOC) begin
					if (fit) begin
						granted_d = mem_rdata.rstart;
						if (new_start == mem_rdata.rend) begin
							// range used up: close the gap
							if (more) begin
								state_d = S_SHDN;
							end else begin
								count_d = cnt_m1;
								state_d = S_RESP;
							end
						end else begin
							mem_we    = 1'b1;
							mem_waddr = idx_q[IDX_W-1:0];
							mem_wdata = '{rstart: new_start, rend: mem_rdata.rend};
							state_d   = S_RESP;
						end
					end else if (more) begin
						idx_d = idx_p1;
					end else begin
						status_d = ST_NOFIT;
						state_d  = S_RESP;
					end
				end else begin
					if (mem_rdata.rstart <= req_q.release_start) begin
						prev_d = mem_rdata;
						hp_d   = 1'b1;
						if (more) begin
							idx_d = idx_p1;
						end else begin
							pos_d   = count_q;
							state_d = S_REL;
						end
					end else begin
						pos_d   = idx_q;
						next_d  = mem_rdata;
						hn_d    = 1'b1;
						state_d = S_REL;
					end
				end
			end
			// merge or insert at the found position, or report a full list
			S_REL: begin
				if (mprev && mnext) begin
					mem_we    = 1'b1;
					mem_waddr = pos_m1[IDX_W-1:0];
					mem_wdata = '{rstart: prev_q.rstart, rend: next_q.rend};
					if (pos_p1 < count_q) begin
						mem_re    = 1'b1;
						mem_raddr = pos_p1[IDX_W-1:0];
						idx_d     = pos_q;
						state_d   = S_SHDN;
					end else begin
						count_d = cnt_m1;
						state_d = S_RESP;
					end
				end else if (mprev) begin
					mem_we    = 1'b1;
					mem_waddr = pos_m1[IDX_W-1:0];
					mem_wdata = '{rstart: prev_q.rstart, rend: req_q.release_end};
					state_d   = S_RESP;
				end else if (mnext) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[IDX_W-1:0];
					mem_wdata = '{rstart: req_q.release_start, rend: next_q.rend};
					state_d   = S_RESP;
				end else if (count_q >= FULL) begin
					status_d = ST_FULL;
					state_d  = S_RESP;
				end else if (pos_q == count_q) begin
					state_d = S_INS;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cnt_m1[IDX_W-1:0];
					idx_d     = count_q;
					state_d   = S_SHUP;
				end
			end
			// entry idx+1 moves down to idx
			S_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
				if (idx_p2 < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_p2[IDX_W-1:0];
					idx_d     = idx_p1;
				end else begin
					count_d = cnt_m1;
					state_d = S_RESP;
				end
			end
			// entry idx-1 moves up to idx
			S_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
				if (idx_m1 > pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_m2[IDX_W-1:0];
					idx_d     = idx_m1;
				end else begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[IDX_W-1:0];
				mem_wdata = '{rstart: req_q.release_start, rend: req_q.release_end};
				count_d   = count_q + ONE;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			count_q <= ONE;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		req_q     <= req_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		prev_q    <= prev_d;
		next_q    <= next_d;
		hp_q      <= hp_d;
		hn_q      <= hn_d;
		status_q  <= status_d;
		granted_q <= granted_d;
	end

	// list never grows past its depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("free range count above depth");

	// no access pattern reads the entry being written
	a_no_rw_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write of same entry");

	// scan stays inside the valid part of the list
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q < count_q))
		else $error("scan beyond list");

	// shift-down source entry is valid
	a_shdn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHDN) |-> (idx_p1 < count_q))
		else $error("shift down beyond list");

	// count changes by at most one per step
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_INIT) |=>
			(count_q == $past(count_q) || count_q == $past(count_q) + ONE ||
			count_q == $past(count_q) - ONE))
		else $error("count jumped");

endmodule

`default_nettype wire

### rtl/core/first_fit_range_allocator.sv
// Top level: first-fit free-range allocator with coalescing.
`default_nettype none

// A sorted list of up to 64 free slot ranges sits in one RAM with a single
// read and a single write port; each request is handled alone and gets one
// response. Allocate scans entries one per cycle for the first range that is
// long enough, then, if that range is used up, shifts the rest down one entry
// per cycle. Release scans to its sorted position, merges with touching
// neighbors, and otherwise shifts entries up one per cycle to open a hole.
// After reset the block writes the initial range before it takes its first
// item. pool_size may be written at any time and is used by the next
// reinitialize.
module first_fit_range_allocator
	import ffra_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [SLOT_W-1:0] cfg_wr_data,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp
);

	logic [SLOT_W-1:0] pool_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              rsp_free;
	done_t             done;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	range_t            mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	range_t            mem_rdata;

	// pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
		end else if (cfg_wr_en) begin
			pool_q <= cfg_wr_data;
		end
	end

	// sequencer
	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.pool_size (pool_q),
		.rsp_free  (rsp_free),
		.done      (done),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// free range list storage
	ffra_ram #(
		.DEPTH (FREE_SLOTS),
		.WIDTH (RANGE_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: takes a new item once the held one is gone
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done.valid && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid && rsp_free) begin
			rsp_q <= done.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### sim/tb_first_fit_range_allocator.sv
// Testbench for first_fit_range_allocator: directed and random requests checked against a free-list model.
`timescale 1ns / 1ps

module tb_first_fit_range_allocator;
	import ffra_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
	localparam int RANDOM_ITEMS = 111;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [SLOT_W-1:0] cfg_wr_data = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;

	// model of the free list and the pool size register
	logic [SLOT_W-1:0] model_start [FREE_SLOTS];
	logic [SLOT_W-1:0] model_end [FREE_SLOTS];
	int                model_count;
	logic [SLOT_W-1:0] model_pool;

	// responses still owed by the block, oldest first
	rsp_t expected_rsp_q [$];

	// ranges granted so far and not yet given back; used to build well-formed releases
	logic [SLOT_W-1:0] held_start_q [$];
	logic [SLOT_W-1:0] held_end_q [$];

	first_fit_range_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- model

	function automatic void model_reinit(logic [SLOT_W-1:0] size);
		for (int i = 0; i < FREE_SLOTS; i++) begin
			model_start[i] = '0;
			model_end[i] = '0;
		end
		model_end[0] = size;
		model_count = (size != '0) ? 1 : 0;
		held_start_q.delete();
		held_end_q.delete();
	endfunction

	function automatic void model_drop(int idx);
		for (int i = idx; i + 1 < model_count; i++) begin
			model_start[i] = model_start[i + 1];
			model_end[i] = model_end[i + 1];
		end
		model_count--;
	endfunction

	// applies one request to the free list and returns the response it earns
	function automatic rsp_t model_apply(req_t r);
		rsp_t o;
		int   pos;
		logic found;
		logic mprev;
		logic mnext;
		o = '0;
		o.status = ST_IGNORED;
		case (r.mode)
			MODE_ALLOC: begin
				if (r.alloc_length != '0) begin
					o.status = ST_NOFIT;
					found = 1'b0;
					for (int i = 0; i < model_count && !found; i++) begin
						if (model_end[i] - model_start[i] >= r.alloc_length) begin
							found = 1'b1;
							o.status = ST_DONE;
							o.granted_start = model_start[i];
							held_start_q.insert(held_start_q.size(), model_start[i]);
							held_end_q.insert(held_end_q.size(),
								model_start[i] + r.alloc_length);
							model_start[i] += r.alloc_length;
							if (model_start[i] >= model_end[i])
								model_drop(i);
						end
					end
				end
			end
			MODE_RELEASE: begin
				if (r.release_end > r.release_start) begin
					pos = 0;
					while (pos < model_count && model_start[pos] <= r.release_start)
						pos++;
					mprev = 1'b0;
					mnext = 1'b0;
					if (pos > 0)
						mprev = (model_end[pos - 1] == r.release_start);
					if (pos < model_count)
						mnext = (model_start[pos] == r.release_end);
					o.status = ST_DONE;
					if (mprev && mnext) begin
						model_end[pos - 1] = model_end[pos];
						model_drop(pos);
					end else if (mprev) begin
						model_end[pos - 1] = r.release_end;
					end else if (mnext) begin
						model_start[pos] = r.release_start;
					end else if (model_count >= FREE_SLOTS) begin
						o.status = ST_FULL;
					end else begin
						for (int i = model_count; i > pos; i--) begin
							model_start[i] = model_start[i - 1];
							model_end[i] = model_end[i - 1];
						end
						model_start[pos] = r.release_start;
						model_end[pos] = r.release_end;
						model_count++;
					end
				end
			end
			MODE_REINIT: begin
				model_reinit(model_pool);
				o.status = ST_DONE;
			end
			default: ;
		endcase
		o.free_range_count = 7'(model_count);
		return o;
	endfunction

	// ---------------------------------------------------------------- driving

	function automatic req_t make_req(logic [1:0] mode, logic [SLOT_W-1:0] len,
			logic [SLOT_W-1:0] rs, logic [SLOT_W-1:0] re);
		req_t r;
		r.mode = mode;
		r.alloc_length = len;
		r.release_start = rs;
		r.release_end = re;
		return r;
	endfunction

	// presents one item, holds it until accepted, then records its expected response
	task automatic send_req(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_rsp_q.insert(expected_rsp_q.size(), model_apply(r));
	endtask

	// stops sending and waits until every owed response has come back
	task automatic drain_responses;
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pool_size(logic [SLOT_W-1:0] size);
		drain_responses();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= size;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_pool = size;
	endtask

	// receiver back-pressure
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %h", $time, rsp);
				fail_count++;
			end else begin
				want_rsp = expected_rsp_q.pop_front();
				check_field("status", 32'(want_rsp.status), 32'(rsp.status));
				check_field("granted_start", 32'(want_rsp.granted_start),
					32'(rsp.granted_start));
				check_field("free_range_count", 32'(want_rsp.free_range_count),
					32'(rsp.free_range_count));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// corner cases starting from the reset list [0, 41000000)
	task automatic test_directed;
		send_req(make_req(MODE_ALLOC, '0, '0, '0));
		send_req(make_req(MODE_ALLOC, SLOT_MAX, '0, '0));
		send_req(make_req(MODE_ALLOC, POOL_RESET, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd1, '0, '0));
		send_req(make_req(MODE_RELEASE, '0, 27'd0, 27'd100));
		send_req(make_req(MODE_RELEASE, '0, 27'd200, 27'd300));
		send_req(make_req(MODE_RELEASE, '0, 27'd100, 27'd200));
		send_req(make_req(MODE_RELEASE, '0, 27'd300, 27'd400));
		send_req(make_req(MODE_RELEASE, '0, 27'd500, 27'd600));
		send_req(make_req(MODE_RELEASE, '0, 27'd450, 27'd500));
		// inverted, empty and overlapping releases
		send_req(make_req(MODE_RELEASE, '0, 27'd50, 27'd40));
		send_req(make_req(MODE_RELEASE, '0, 27'd7, 27'd7));
		send_req(make_req(MODE_RELEASE, '0, SLOT_MAX, '0));
		send_req(make_req(MODE_RELEASE, '0, 27'd10, 27'd20));
		send_req(make_req(2'd3, SLOT_MAX, SLOT_MAX, SLOT_MAX));
		send_req(make_req(MODE_RELEASE, '0, SLOT_MAX - 27'd1, SLOT_MAX));
		send_req(make_req(MODE_ALLOC, 27'd5, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd200, '0, '0));
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd1, '0, '0));
	endtask

	// pool sizes at the edges, including zero which leaves the list empty
	task automatic test_pool_extremes;
		write_pool_size('0);
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd1, '0, '0));
		write_pool_size(27'd1);
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd1, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd1, '0, '0));
		write_pool_size(SLOT_MAX);
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		send_req(make_req(MODE_ALLOC, SLOT_MAX, '0, '0));
	endtask

	// fill all 64 entries, then check that only merging releases get in while the list is full
	task automatic test_list_full;
		write_pool_size('0);
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		for (int k = 0; k < FREE_SLOTS; k++)
			send_req(make_req(MODE_RELEASE, '0, SLOT_W'(10 * k), SLOT_W'(10 * k + 5)));
		send_req(make_req(MODE_RELEASE, '0, 27'd640, 27'd645));
		send_req(make_req(MODE_RELEASE, '0, 27'd635, 27'd638));
		send_req(make_req(MODE_RELEASE, '0, 27'd700, 27'd710));
		send_req(make_req(MODE_RELEASE, '0, 27'd5, 27'd10));
		send_req(make_req(MODE_RELEASE, '0, 27'd20, 27'd25));
		send_req(make_req(MODE_ALLOC, 27'd6, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd5, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd4, '0, '0));
		send_req(make_req(MODE_ALLOC, 27'd5, '0, '0));
	endtask

	// mostly allocate/give-back traffic on live ranges, with some malformed requests
	task automatic test_random_traffic(logic [SLOT_W-1:0] pool, int idle_pct, int stall_pct);
		req_t              r;
		int                pick;
		int                k;
		logic [SLOT_W-1:0] span;
		logic [SLOT_W-1:0] base;
		write_pool_size(pool);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		send_req(make_req(MODE_REINIT, '0, '0, '0));
		span = (pool >> 3) + 27'd1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = '0;
			pick = $urandom_range(99);
			if (pick >= 40 && pick < 80 && held_start_q.size() == 0)
				pick = 0;
			if (pick < 40) begin
				r.mode = MODE_ALLOC;
				case ($urandom_range(9))
					0: r.alloc_length = SLOT_W'($urandom_range(span, 1));
					1: r.alloc_length = SLOT_W'($urandom);
					default: r.alloc_length = SLOT_W'($urandom_range(16, 1));
				endcase
			end else if (pick < 80) begin
				k = $urandom_range(held_start_q.size() - 1);
				r.mode = MODE_RELEASE;
				r.release_start = held_start_q[k];
				r.release_end = held_end_q[k];
				held_start_q.delete(k);
				held_end_q.delete(k);
			end else if (pick < 84) begin
				r.mode = MODE_REINIT;
			end else begin
				case ($urandom_range(4))
					0: r.mode = MODE_ALLOC;
					1: r = make_req(2'd3, SLOT_W'($urandom), SLOT_W'($urandom),
						SLOT_W'($urandom));
					2: begin
						base = SLOT_W'($urandom);
						r = make_req(MODE_RELEASE, SLOT_W'($urandom), base,
							SLOT_W'($urandom_range(base)));
					end
					3: r = make_req(MODE_RELEASE, SLOT_W'($urandom), SLOT_W'($urandom),
						SLOT_W'($urandom));
					default: begin
						// lands on or next to live ranges, often overlapping them
						base = SLOT_W'($urandom_range(pool));
						r = make_req(MODE_RELEASE, '0, base,
							base + SLOT_W'($urandom_range(32, 1)));
					end
				endcase
			end
			send_req(r);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		model_pool = POOL_RESET;
		model_reinit(POOL_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_extremes();
		test_list_full();
		test_random_traffic(27'd256, 0, 0);
		test_random_traffic(27'd4096, 65, 0);
		test_random_traffic(SLOT_MAX, 0, 65);
		test_random_traffic(27'd1000, 13, 13);
		drain_responses();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** first_fit_range_allocator: PASSED **");
		else
			$display("** first_fit_range_allocator: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(10_000_000);
		$display("** first_fit_range_allocator: FAILED **");
		$finish;
	end

endmodule

### first_fit_range_allocator.f
rtl/core/ffra_pkg.sv
rtl/core/ffra_ram.sv
rtl/core/ffra_ctrl.sv
rtl/core/first_fit_range_allocator.sv
sim/tb_first_fit_range_allocator.sv
